@@ sv/mtde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_pkg
// types, codes and constants shared by the timer deadline engine
// ----------------------------------------------------------------------------
package mtde_pkg;

  localparam int unsigned NumTimersDef = 16;
  localparam int unsigned TimeW        = 63;
  localparam int unsigned PerW         = 32;
  localparam int unsigned CfgW         = 32;
  localparam int unsigned IdxW         = 4;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // configuration register indexes
  localparam logic CfgMinInterval = 1'b0;
  localparam logic CfgMaxInterval = 1'b1;

  localparam logic [CfgW-1:0] MinIntervalRst = 32'd1;
  localparam logic [CfgW-1:0] MaxIntervalRst = 32'd1000000;

  typedef enum logic [1:0] {
    OP_ARM     = 2'd0,
    OP_DISARM  = 2'd1,
    OP_SERVICE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EV_FIRED = 2'd0,
    EV_PROG  = 2'd1,
    EV_DONE  = 2'd2
  } ev_kind_e;

  typedef struct packed {
    logic accept;
    logic arm_write;
    logic disarm;
    logic clear_valid;
    logic scan_start;
    logic cand_val;
    logic cand_best;
    logic scan_rd;
    logic scan_take;
    logic scan_adv;
    logic emit_fire;
    logic rem_start;
    logic clear_slot;
    logic upd_per;
    logic set_hw_raw;
    logic emit_prog;
    logic emit_done;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_ok;
    logic slot_armed;
    logic expired;
    logic periodic;
    logic scan_last;
    logic rem_busy;
    logic out_free;
    logic cand_zero;
    logic cand_blocked;
    logic cand_future;
  } ctrl_sts_t;

endpackage

@@ sv/mtde_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_in_if / mtde_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface mtde_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  timer_index;
  logic [62:0] cur_time;
  logic [62:0] arm_value;
  logic [31:0] arm_period;

  modport source (output valid, output operation, output timer_index,
                  output cur_time, output arm_value, output arm_period,
                  input ready);
  modport sink (input valid, input operation, input timer_index,
                input cur_time, input arm_value, input arm_period,
                output ready);
endinterface

interface mtde_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [3:0]  fired_index;
  logic [31:0] hw_gap;
  logic [62:0] hw_deadline_out;
  logic        disarm_error;
  logic        last;

  modport source (output valid, output event_kind, output fired_index,
                  output hw_gap, output hw_deadline_out, output disarm_error,
                  output last, input ready);
  modport sink (input valid, input event_kind, input fired_index,
                input hw_gap, input hw_deadline_out, input disarm_error,
                input last, output ready);
endinterface

@@ sv/mtde_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_rem
// bit-serial restoring remainder, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mtde_rem
  import mtde_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  input  logic [PerW-1:0]  divisor_i,
  output logic             busy_o,
  output logic [PerW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(TimeW + 1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW-1:0] x_q, x_d;
  logic [PerW-1:0]  r_q, r_d;
  logic [PerW:0]    shifted;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    r_d     = r_q;
    shifted = {r_q, x_q[TimeW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(TimeW);
      x_d    = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      x_d = {x_q[TimeW-2:0], 1'b0};
      if (shifted >= {1'b0, divisor_i}) begin
        r_d = PerW'(shifted - {1'b0, divisor_i});
      end else begin
        r_d = shifted[PerW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

endmodule

@@ sv/mtde_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_dpath
// slot table, hardware deadline, clamp arithmetic and result register
// ----------------------------------------------------------------------------
module mtde_dpath
  import mtde_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output ctrl_sts_t        sts_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic [1:0]       operation_i,
  input  logic [IdxW-1:0]  timer_index_i,
  input  logic [TimeW-1:0] cur_time_i,
  input  logic [TimeW-1:0] arm_value_i,
  input  logic [PerW-1:0]  arm_period_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       event_kind_o,
  output logic [IdxW-1:0]  fired_index_o,
  output logic [PerW-1:0]  hw_gap_o,
  output logic [TimeW-1:0] hw_deadline_out_o,
  output logic             disarm_error_o,
  output logic             last_o
);

  localparam int unsigned SlotW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned EntW  = TimeW + PerW;

  // latched command beat
  op_e              op_q;
  logic [IdxW-1:0]  idx_q;
  logic [TimeW-1:0] now_q, val_q;
  logic [PerW-1:0]  per_q;
  logic             err_q;

  logic [CfgW-1:0]  min_q, max_q;

  logic [EntW-1:0]  slot_mem [NUM_TIMERS];
  logic [EntW-1:0]  rd_q;
  logic [NUM_TIMERS-1:0] armed_q;

  logic [SlotW-1:0] cnt_q, idx_w;
  logic [TimeW-1:0] best_q, cand_q, hw_q;
  logic             hw_valid_q;
  logic [PerW-1:0]  gap_q, gap_d;
  logic [TimeW-1:0] diff, g1;

  logic [TimeW-1:0] rd_dl;
  logic [PerW-1:0]  rd_per, rem_r;
  logic             rem_busy;
  logic [TimeW:0]   nd_wide, dl_wide;
  logic [TimeW-1:0] nd, dl;
  logic             idx_ok;

  logic             mem_we;
  logic [SlotW-1:0] mem_wa;
  logic [EntW-1:0]  mem_wd;

  logic             out_valid_q, out_free;
  logic [1:0]       kind_q;
  logic [IdxW-1:0]  fidx_q;
  logic [PerW-1:0]  ogap_q;
  logic [TimeW-1:0] odl_q;
  logic             oerr_q, olast_q;

  assign idx_w  = SlotW'(idx_q);
  assign idx_ok = {4'b0, idx_q} < 8'(NUM_TIMERS);
  assign rd_dl  = rd_q[EntW-1:PerW];
  assign rd_per = rd_q[PerW-1:0];

  // periodic catch-up: now - ((now - d) mod p) + p, saturated
  assign nd_wide = {1'b0, now_q} - {{(TimeW+1-PerW){1'b0}}, rem_r}
                   + {{(TimeW+1-PerW){1'b0}}, rd_per};
  assign nd      = nd_wide[TimeW] ? TimeMax : nd_wide[TimeW-1:0];

  mtde_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (now_q - rd_dl),
    .divisor_i  (rd_per),
    .busy_o     (rem_busy),
    .rem_o      (rem_r)
  );

  // clamp: raise to min, then lower to max
  always_comb begin
    diff  = cand_q - now_q;
    g1    = (diff < {31'b0, min_q}) ? {31'b0, min_q} : diff;
    gap_d = (g1 > {31'b0, max_q}) ? max_q : g1[PerW-1:0];
  end

  assign dl_wide = {1'b0, now_q} + {{(TimeW+1-PerW){1'b0}}, gap_q};
  assign dl      = dl_wide[TimeW] ? TimeMax : dl_wide[TimeW-1:0];

  assign mem_we = cmd_i.arm_write | cmd_i.upd_per;
  assign mem_wa = cmd_i.arm_write ? idx_w : cnt_q;
  assign mem_wd = cmd_i.arm_write ? {val_q, per_q} : {nd, rd_per};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.scan_rd) begin
      rd_q <= slot_mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(operation_i);
      idx_q <= timer_index_i;
      now_q <= cur_time_i;
      val_q <= arm_value_i;
      per_q <= arm_period_i;
    end
    gap_q <= gap_d;
    if (cmd_i.scan_start) begin
      best_q <= TimeMax;
    end else if (cmd_i.scan_take && armed_q[cnt_q] && rd_dl < best_q) begin
      best_q <= rd_dl;
    end else if (cmd_i.upd_per && nd < best_q) begin
      best_q <= nd;
    end
    if (cmd_i.cand_val) begin
      cand_q <= val_q;
    end else if (cmd_i.cand_best) begin
      cand_q <= best_q;
    end
    if (cmd_i.set_hw_raw) begin
      hw_q <= cand_q;
    end else if (cmd_i.emit_prog) begin
      hw_q <= dl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= MinIntervalRst;
      max_q      <= MaxIntervalRst;
      armed_q    <= '0;
      hw_valid_q <= 1'b0;
      cnt_q      <= '0;
      err_q      <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgMinInterval) begin
        min_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CfgMaxInterval) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        err_q <= 1'b0;
      end else if (cmd_i.disarm) begin
        err_q <= !(idx_ok && armed_q[idx_w]);
      end
      if (cmd_i.arm_write) begin
        armed_q[idx_w] <= 1'b1;
      end else if (cmd_i.disarm && idx_ok) begin
        armed_q[idx_w] <= 1'b0;
      end else if (cmd_i.clear_slot) begin
        armed_q[cnt_q] <= 1'b0;
      end
      if (cmd_i.clear_valid) begin
        hw_valid_q <= 1'b0;
      end else if (cmd_i.set_hw_raw || cmd_i.emit_prog) begin
        hw_valid_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_adv) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_fire || cmd_i.emit_prog || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fire || cmd_i.emit_prog || cmd_i.emit_done) begin
      kind_q  <= cmd_i.emit_fire ? EV_FIRED : (cmd_i.emit_prog ? EV_PROG : EV_DONE);
      fidx_q  <= cmd_i.emit_fire ? IdxW'(cnt_q) : '0;
      ogap_q  <= cmd_i.emit_prog ? gap_q : '0;
      odl_q   <= cmd_i.emit_prog ? dl : '0;
      oerr_q  <= cmd_i.emit_done ? err_q : 1'b0;
      olast_q <= cmd_i.emit_done;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = kind_q;
  assign fired_index_o     = fidx_q;
  assign hw_gap_o          = ogap_q;
  assign hw_deadline_out_o = odl_q;
  assign disarm_error_o    = oerr_q;
  assign last_o            = olast_q;

  always_comb begin
    sts_o.op           = op_q;
    sts_o.idx_ok       = idx_ok;
    sts_o.slot_armed   = armed_q[cnt_q];
    sts_o.expired      = rd_dl <= now_q;
    sts_o.periodic     = rd_per != '0;
    sts_o.scan_last    = cnt_q == SlotW'(NUM_TIMERS - 1);
    sts_o.rem_busy     = rem_busy;
    sts_o.out_free     = out_free;
    sts_o.cand_zero    = cand_q == '0;
    sts_o.cand_blocked = hw_valid_q && cand_q >= hw_q;
    sts_o.cand_future  = cand_q >= now_q;
  end

endmodule

@@ sv/mtde_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_ctrl
// sequencer for arm, disarm, service scan and hardware reprogramming
// ----------------------------------------------------------------------------
module mtde_ctrl
  import mtde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DECODE  = 10'b00_0000_0010,
    S_PROG    = 10'b00_0000_0100,
    S_EMITPRG = 10'b00_0000_1000,
    S_SCANRD  = 10'b00_0001_0000,
    S_SCANEV  = 10'b00_0010_0000,
    S_FIRE    = 10'b00_0100_0000,
    S_REM     = 10'b00_1000_0000,
    S_NEXT    = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   depth_q, depth_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          depth_d      = 1'b0;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_ARM: begin
            if (sts_i.idx_ok) begin
              cmd_o.arm_write = 1'b1;
              cmd_o.cand_val  = 1'b1;
              state_d         = S_PROG;
            end else begin
              state_d = S_DONE;
            end
          end
          OP_DISARM: begin
            cmd_o.disarm = 1'b1;
            state_d      = S_DONE;
          end
          OP_SERVICE: begin
            cmd_o.clear_valid = 1'b1;
            cmd_o.scan_start  = 1'b1;
            depth_d           = 1'b1;
            state_d           = S_SCANRD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PROG: begin
        if (sts_i.cand_zero || sts_i.cand_blocked) begin
          state_d = S_DONE;
        end else if (sts_i.cand_future) begin
          state_d = S_EMITPRG;
        end else if (!depth_q) begin
          // deadline already past: run the service scan now
          cmd_o.clear_valid = 1'b1;
          cmd_o.scan_start  = 1'b1;
          depth_d           = 1'b1;
          state_d           = S_SCANRD;
        end else begin
          cmd_o.set_hw_raw = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_EMITPRG: begin
        if (sts_i.out_free) begin
          cmd_o.emit_prog = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_SCANRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCANEV;
      end
      S_SCANEV: begin
        if (sts_i.slot_armed && sts_i.expired) begin
          state_d = S_FIRE;
        end else begin
          cmd_o.scan_take = 1'b1;
          state_d         = S_NEXT;
        end
      end
      S_FIRE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fire = 1'b1;
          if (sts_i.periodic) begin
            cmd_o.rem_start = 1'b1;
            state_d         = S_REM;
          end else begin
            cmd_o.clear_slot = 1'b1;
            state_d          = S_NEXT;
          end
        end
      end
      S_REM: begin
        if (!sts_i.rem_busy) begin
          cmd_o.upd_per = 1'b1;
          state_d       = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.scan_last) begin
          cmd_o.cand_best = 1'b1;
          state_d         = S_PROG;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SCANRD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_rem_periodic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rem_start |-> (state_q == S_FIRE && sts_i.periodic))
    else $error("catch-up started for a one-shot slot");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_DECODE)
    else $error("accepted beat not decoded");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_fire, cmd_o.emit_prog, cmd_o.emit_done}))
    else $error("two result beats loaded at once");

endmodule

@@ sv/multi_timer_deadline_engine_core.sv @@
`timescale 1ns / 1ps
// disarm, no-op and out-of-range arm go straight to the done beat; an in-range arm writes
//   the slot, then may reprogram the hardware timer or, for a past deadline, run a scan
// service: reads every slot, emits a fired beat per fired slot and runs the 63-step
//   serial remainder per fired periodic slot, then programs and ends; output stalls hold it
// one command beat is in flight at a time; the next is taken once the done beat is loaded
// reset: all slots disarmed, hardware deadline invalid, intervals 1 and 1000000
// ----------------------------------------------------------------------------
// multi_timer_deadline_engine_core
// software timer table with next-deadline hardware timer programming
// ----------------------------------------------------------------------------
module multi_timer_deadline_engine_core
  import mtde_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtde_in_if.sink         item_i,
  mtde_out_if.source      result_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: walks arm/disarm/service and the reprogramming rule
  mtde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: slot table memory, clamp, catch-up unit and result register
  mtde_dpath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (item_i.operation),
    .timer_index_i     (item_i.timer_index),
    .cur_time_i        (item_i.cur_time),
    .arm_value_i       (item_i.arm_value),
    .arm_period_i      (item_i.arm_period),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .event_kind_o      (result_o.event_kind),
    .fired_index_o     (result_o.fired_index),
    .hw_gap_o          (result_o.hw_gap),
    .hw_deadline_out_o (result_o.hw_deadline_out),
    .disarm_error_o    (result_o.disarm_error),
    .last_o            (result_o.last)
  );

endmodule
